FILE: rtl/core/tsrd_pkg.sv
// ----------------------------------------------------------------------------
// tsrd_pkg
// Shared types, constants and the byte-wide CRC8 update for the scratchpad
// readout decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrd_pkg;

    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 4;
    localparam int TEMP_W     = 16;
    localparam int RES_W      = 4;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    // byte positions within one scratchpad readout
    localparam logic [INDEX_W-1:0] IDX_TEMP_LOW  = 4'd0;
    localparam logic [INDEX_W-1:0] IDX_TEMP_HIGH = 4'd1;
    localparam logic [INDEX_W-1:0] IDX_CONFIG    = 4'd4;
    localparam logic [INDEX_W-1:0] IDX_CRC       = 4'd8;
    localparam logic [INDEX_W-1:0] IDX_IDLE      = 4'd9;

    // reflected form of x^8+x^5+x^4+1
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    localparam logic [RES_W-1:0] RES_BITS_BASE = 4'd9;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_MIN    = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_MAX    = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_CHECK_ON = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CHECK_ON = 8'd3;

    localparam logic signed [TEMP_W-1:0] RANGE_MIN_RESET = 16'sh8000;
    localparam logic signed [TEMP_W-1:0] RANGE_MAX_RESET = 16'sh7FFF;

    typedef enum logic [1:0] {
        RES_9B  = 2'd0,
        RES_10B = 2'd1,
        RES_11B = 2'd2,
        RES_12B = 2'd3
    } res_code_t;

    typedef struct packed {
        logic [BYTE_W-1:0] scratch_byte;
        logic              frame_start;
    } tsrd_in_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [RES_W-1:0]         resolution_bits;
        logic                     crc_ok;
        logic                     plausible;
    } tsrd_out_t;

    // status from the frame tracker to the converter and the result register
    typedef struct packed {
        logic              last;
        logic              crc_ok;
        logic [BYTE_W-1:0] temp_low;
        logic [BYTE_W-1:0] temp_high;
        res_code_t         res_code;
    } tsrd_frame_t;

    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/temp_scratchpad_readout_decoder.sv
// ----------------------------------------------------------------------------
// temp_scratchpad_readout_decoder
// Decodes the nine scratchpad bytes of a digital thermometer into one
// temperature result with resolution, CRC match and plausibility flags.
// ----------------------------------------------------------------------------
// One scratchpad byte is accepted per clock. Bytes 0 to 7 produce nothing;
// the CRC byte (byte 8) produces one result word, visible on m_ the cycle
// after it is accepted. A byte with frame_start set always begins a new
// frame, and bytes outside a frame are dropped. s_ready only falls while the
// result register holds a word that m_ready has not yet taken, so the input
// side runs at one byte per cycle as long as results are drained. Limits are
// written through the cfg_ port, which is always ready.
`default_nettype none

module temp_scratchpad_readout_decoder (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire tsrd_pkg::tsrd_in_t                  s_data,
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      tsrd_pkg::tsrd_out_t                 m_data,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [tsrd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [tsrd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tsrd_pkg::*;

    logic                      s_accept;
    tsrd_frame_t               status;
    logic signed [TEMP_W-1:0]  range_min_reg;
    logic signed [TEMP_W-1:0]  range_max_reg;
    logic                      min_check_on_reg;
    logic                      max_check_on_reg;
    logic signed [TEMP_W-1:0]  temp_centi;
    logic [RES_W-1:0]          resolution_bits;
    logic                      plausible;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    tsrd_out_t                 m_data_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg    <= RANGE_MIN_RESET;
            range_max_reg    <= RANGE_MAX_RESET;
            min_check_on_reg <= 1'b0;
            max_check_on_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_RANGE_MIN:    range_min_reg    <= cfg_data;
                REG_RANGE_MAX:    range_max_reg    <= cfg_data;
                REG_MIN_CHECK_ON: min_check_on_reg <= cfg_data[0];
                REG_MAX_CHECK_ON: max_check_on_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    tsrd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .in_word (s_data),
        .status  (status)
    );

    tsrd_conv u_conv (
        .aclk            (aclk),
        .status          (status),
        .range_min       (range_min_reg),
        .range_max       (range_max_reg),
        .min_check_on    (min_check_on_reg),
        .max_check_on    (max_check_on_reg),
        .temp_centi      (temp_centi),
        .resolution_bits (resolution_bits),
        .plausible       (plausible)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (s_accept && status.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && status.last) begin
            m_data_reg.temp_centi      <= temp_centi;
            m_data_reg.resolution_bits <= resolution_bits;
            m_data_reg.crc_ok          <= status.crc_ok;
            m_data_reg.plausible       <= plausible;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_result_from_crc_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_accept && status.last))
        else $error("result raised without a CRC byte");

    a_resolution_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.resolution_bits >= RES_BITS_BASE
                      && m_data_reg.resolution_bits <= RES_BITS_BASE + 4'd3))
        else $error("resolution out of range");

endmodule

`default_nettype wire

FILE: rtl/core/tsrd_frame.sv
// ----------------------------------------------------------------------------
// tsrd_frame
// Tracks the byte position within a readout, runs the CRC8 over bytes 0-7
// and captures the temperature bytes and the resolution code.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrd_frame (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire tsrd_pkg::tsrd_in_t          in_word,
    output      tsrd_pkg::tsrd_frame_t       status
);
    import tsrd_pkg::*;

    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic [BYTE_W-1:0]  crc_reg;
    logic [BYTE_W-1:0]  crc_next;
    logic [BYTE_W-1:0]  temp_low_reg;
    logic [BYTE_W-1:0]  temp_high_reg;
    res_code_t          res_code_reg;
    logic [INDEX_W-1:0] cur_index;
    logic [BYTE_W-1:0]  cur_crc;

    // a frame start restarts counting and the CRC on this very byte
    always_comb begin
        cur_index = in_word.frame_start ? IDX_TEMP_LOW : index_reg;
        cur_crc   = in_word.frame_start ? '0 : crc_reg;
    end

    always_comb begin
        index_next = index_reg;
        crc_next   = crc_reg;
        if (accept) begin
            if (cur_index < IDX_CRC) begin
                index_next = cur_index + 4'd1;
                crc_next   = crc8_byte(cur_crc, in_word.scratch_byte);
            end else begin
                index_next = IDX_IDLE;
                crc_next   = cur_crc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= IDX_IDLE;
            crc_reg   <= '0;
        end else begin
            index_reg <= index_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (cur_index == IDX_TEMP_LOW) begin
                temp_low_reg <= in_word.scratch_byte;
            end
            if (cur_index == IDX_TEMP_HIGH) begin
                temp_high_reg <= in_word.scratch_byte;
            end
            if (cur_index == IDX_CONFIG) begin
                res_code_reg <= res_code_t'(in_word.scratch_byte[6:5]);
            end
        end
    end

    always_comb begin
        status.last      = (cur_index == IDX_CRC);
        status.crc_ok    = (crc_reg == in_word.scratch_byte);
        status.temp_low  = temp_low_reg;
        status.temp_high = temp_high_reg;
        status.res_code  = res_code_reg;
    end

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        index_reg <= IDX_IDLE)
        else $error("byte index out of range");

    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_word.frame_start |=> index_reg == IDX_TEMP_HIGH)
        else $error("frame start did not restart the byte count");

endmodule

`default_nettype wire

FILE: rtl/core/tsrd_conv.sv
// ----------------------------------------------------------------------------
// tsrd_conv
// Masks the raw temperature by resolution, scales it to centi-degrees with
// saturation and checks it against the enabled limits.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrd_conv (
    input  wire logic                                aclk,
    input  wire tsrd_pkg::tsrd_frame_t               status,
    input  wire logic signed [tsrd_pkg::TEMP_W-1:0]  range_min,
    input  wire logic signed [tsrd_pkg::TEMP_W-1:0]  range_max,
    input  wire logic                                min_check_on,
    input  wire logic                                max_check_on,
    output      logic signed [tsrd_pkg::TEMP_W-1:0]  temp_centi,
    output      logic [tsrd_pkg::RES_W-1:0]          resolution_bits,
    output      logic                                plausible
);
    import tsrd_pkg::*;

    logic [TEMP_W-1:0]          pattern;
    logic signed [TEMP_W+4:0]   product;
    logic signed [TEMP_W+4:0]   biased;
    logic signed [TEMP_W+2:0]   quotient;
    logic signed [TEMP_W-1:0]   sat_next;
    logic signed [TEMP_W-1:0]   centi_reg;

    always_comb begin
        pattern = {status.temp_high, status.temp_low};
        unique case (status.res_code)
            RES_9B:  pattern[2:0] = 3'b000;
            RES_10B: pattern[1:0] = 2'b00;
            RES_11B: pattern[0]   = 1'b0;
            RES_12B: pattern      = pattern;
            default: pattern      = pattern;
        endcase
    end

    // raw * 25 / 4, rounding toward zero
    always_comb begin
        product  = $signed({{5{pattern[TEMP_W-1]}}, pattern}) * 21'sd25;
        biased   = product + (product[TEMP_W+4] ? 21'sd3 : 21'sd0);
        quotient = biased[TEMP_W+4:2];
        if (quotient > 19'sd32767) begin
            sat_next = 16'sh7FFF;
        end else if (quotient < -19'sd32768) begin
            sat_next = 16'sh8000;
        end else begin
            sat_next = quotient[TEMP_W-1:0];
        end
    end

    // captures settle at byte 4 and stay put until the CRC byte arrives
    always_ff @(posedge aclk) begin
        centi_reg <= sat_next;
    end

    always_comb begin
        temp_centi      = centi_reg;
        resolution_bits = RES_BITS_BASE + {2'b00, status.res_code};
        plausible       = !(min_check_on && (centi_reg < range_min))
                       && !(max_check_on && (centi_reg > range_max));
    end

endmodule

`default_nettype wire

FILE: tb/sv/tsrd_result_checker.sv
// ----------------------------------------------------------------------------
// tsrd_result_checker
// Watches the scratchpad byte, result and register channels of the readout
// decoder, tracks the frame position, CRC and captured fields itself, and
// compares every result word against the oldest predicted reading.
// ----------------------------------------------------------------------------
module tsrd_result_checker
    import tsrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  tsrd_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  tsrd_out_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted readings, oldest first
    tsrd_out_t readings_q[$];
    tsrd_out_t want;
    int        errs = 0;

    // frame tracking
    logic [INDEX_W-1:0] pos;
    logic [BYTE_W-1:0]  crc_run;
    logic [BYTE_W-1:0]  t_lo;
    logic [BYTE_W-1:0]  t_hi;
    res_code_t          res_sel;

    // limit registers
    logic signed [TEMP_W-1:0] lim_lo;
    logic signed [TEMP_W-1:0] lim_hi;
    logic                     lo_en;
    logic                     hi_en;

    // scratch for the conversion
    logic [TEMP_W-1:0] word;
    int                raw;
    int                centi;
    logic              fb;

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pos     = IDX_IDLE;
            crc_run = '0;
            t_lo    = '0;
            t_hi    = '0;
            res_sel = RES_9B;
            lim_lo  = RANGE_MIN_RESET;
            lim_hi  = RANGE_MAX_RESET;
            lo_en   = 1'b0;
            hi_en   = 1'b0;
            readings_q.delete();
        end else begin
            // a result word can never come from the byte taken at this same edge
            if (m_valid && m_ready) begin
                if (readings_q.size() == 0) begin
                    $error("result word with no reading expected: temp_centi %0d",
                           m_data.temp_centi);
                    errs++;
                end else begin
                    want = readings_q.pop_front();
                    check_field("temp_centi", want.temp_centi, m_data.temp_centi);
                    check_field("resolution_bits", want.resolution_bits,
                                m_data.resolution_bits);
                    check_field("crc_ok", want.crc_ok, m_data.crc_ok);
                    check_field("plausible", want.plausible, m_data.plausible);
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_RANGE_MIN:    lim_lo = cfg_data;
                    REG_RANGE_MAX:    lim_hi = cfg_data;
                    REG_MIN_CHECK_ON: lo_en  = cfg_data[0];
                    REG_MAX_CHECK_ON: hi_en  = cfg_data[0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                if (s_data.frame_start) begin
                    pos     = IDX_TEMP_LOW;
                    crc_run = '0;
                end
                if (pos >= IDX_IDLE) begin
                    pos = IDX_IDLE;
                end else if (pos < IDX_CRC) begin
                    // bitwise dallas crc, lsb first
                    for (int k = 0; k < BYTE_W; k++) begin
                        fb      = crc_run[0] ^ s_data.scratch_byte[k];
                        crc_run = crc_run >> 1;
                        if (fb) begin
                            crc_run = crc_run ^ CRC_POLY;
                        end
                    end
                    case (pos)
                        IDX_TEMP_LOW:  t_lo = s_data.scratch_byte;
                        IDX_TEMP_HIGH: t_hi = s_data.scratch_byte;
                        IDX_CONFIG:    res_sel = res_code_t'(s_data.scratch_byte[6:5]);
                        default: ;
                    endcase
                    pos = pos + 1'b1;
                end else begin
                    word = {t_hi, t_lo};
                    case (res_sel)
                        RES_9B:  word[2:0] = 3'b000;
                        RES_10B: word[1:0] = 2'b00;
                        RES_11B: word[0]   = 1'b0;
                        default: ;
                    endcase
                    raw   = $signed(word);
                    centi = (raw * 25) / 4;
                    if (centi > 32767) begin
                        centi = 32767;
                    end else if (centi < -32768) begin
                        centi = -32768;
                    end
                    want.temp_centi      = centi[TEMP_W-1:0];
                    want.resolution_bits = RES_BITS_BASE + {2'b00, res_sel};
                    want.crc_ok          = (crc_run == s_data.scratch_byte);
                    want.plausible       = !(lo_en && centi < lim_lo) &&
                                           !(hi_en && centi > lim_hi);
                    readings_q.push_back(want);
                    pos = IDX_IDLE;
                end
            end
        end
        fail_count <= errs;
        pending    <= readings_q.size();
    end

endmodule

FILE: tb/sv/tb_temp_scratchpad_readout_decoder.sv
// ----------------------------------------------------------------------------
// tb_temp_scratchpad_readout_decoder
// Feeds scratchpad readouts (clean frames, bad CRCs, cut frames, stray bytes)
// through the decoder under bursty input and a stalling result side, across
// several limit settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_temp_scratchpad_readout_decoder;
    import tsrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 250;
    localparam int DRAIN_WAIT  = 4;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    tsrd_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    tsrd_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;

    int       burst_left = 0;
    bit       gaps_on    = 1'b1;
    int       idle_cycles = 0;
    int       rx_tick    = 0;
    int       rx_mode    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    temp_scratchpad_readout_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    tsrd_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side backpressure, switching among four randomly drawn modes
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_tick % 16 < 4);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_temp_scratchpad_readout_decoder: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // leaves valid high so the next word can follow without a bubble
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid                <= 1'b1;
        s_data.scratch_byte    <= b;
        s_data.frame_start     <= start;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sends the first cut_at bytes of a readout; 9 sends the whole frame
    task automatic send_frame(input logic [TEMP_W-1:0] raw_t, input logic [BYTE_W-1:0] cfg_b,
                              input bit bad_crc, input int cut_at);
        logic [BYTE_W-1:0] fr [9];
        logic [BYTE_W-1:0] crc;
        crc = '0;
        for (int i = 0; i < 8; i++) begin
            fr[i] = 8'($urandom());
        end
        fr[IDX_TEMP_LOW]  = raw_t[7:0];
        fr[IDX_TEMP_HIGH] = raw_t[15:8];
        fr[IDX_CONFIG]    = cfg_b;
        for (int i = 0; i < 8; i++) begin
            crc = crc8_byte(crc, fr[i]);
        end
        fr[IDX_CRC] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
        for (int i = 0; i < cut_at; i++) begin
            send_byte(fr[i], i == 0);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        int                       phase_bytes;
        int                       cut;
        logic [TEMP_W-1:0]        raw_t;
        logic signed [TEMP_W-1:0] lo_lim;
        logic signed [TEMP_W-1:0] hi_lim;
        bit                       lo_en;
        bit                       hi_en;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: stray bytes, saturation both ways, restart mid frame
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_frame(16'h7FFF, 8'h7F, 1'b0, 9);
        send_frame(16'h1234, 8'h5F, 1'b0, 3);
        send_frame(16'h8000, 8'h1F, 1'b1, 9);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                settle();
                lo_lim = 16'(int'($urandom_range(0, 9000)) - 5500);
                hi_lim = 16'(int'($urandom_range(0, 9000)) - 2000);
                lo_en  = 1'b1;
                hi_en  = 1'b1;
                case (phase)
                    1: begin
                        lo_lim = 16'sh8000;
                        hi_lim = 16'sh7FFF;
                    end
                    2: begin
                        lo_lim = '0;
                        hi_lim = '0;
                    end
                    3: begin
                        // inverted window, nothing passes
                        lo_lim = 16'sh7FFF;
                        hi_lim = 16'sh8000;
                    end
                    4: ;
                    5: hi_en = 1'b0;
                    6: lo_en = 1'b0;
                    default: begin
                        lo_lim = 16'($urandom());
                        hi_lim = 16'($urandom());
                        lo_en  = 1'($urandom_range(0, 1));
                        hi_en  = 1'($urandom_range(0, 1));
                    end
                endcase
                write_reg(REG_RANGE_MIN, lo_lim);
                write_reg(REG_RANGE_MAX, hi_lim);
                write_reg(REG_MIN_CHECK_ON, {15'd0, lo_en});
                write_reg(REG_MAX_CHECK_ON, {15'd0, hi_en});
                cfg_valid <= 1'b0;
            end
            gaps_on     = (phase % 3 != 1);
            burst_left  = 0;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: raw_t = 16'h7FFF;
                            1: raw_t = 16'h8000;
                            2: raw_t = 16'h0000;
                            default: raw_t = 16'hFFFF;
                        endcase
                    end
                    1, 2, 3: raw_t = 16'($urandom());
                    // roughly -55 to 125 degrees
                    default: raw_t = 16'(int'($urandom_range(0, 2880)) - 880);
                endcase
                // stray words, landing either outside a frame or inside a cut one
                if ($urandom_range(0, 11) == 0) begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom()), 1'b0);
                end
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 9;
                send_frame(raw_t, 8'($urandom()), $urandom_range(0, 9) < 3, cut);
                phase_bytes += cut;
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("tb_temp_scratchpad_readout_decoder: done, clean");
        end else begin
            $display("tb_temp_scratchpad_readout_decoder: done, errors");
        end
        $finish;
    end

endmodule
